FILE: hw/rtl/csrl_pkg.sv
// shared types, constants and a function for the client session rate limiter
package csrl_pkg;

  localparam int SESSIONS_DEF = 16;
  localparam logic [31:0] TIMEOUT_RESET = 32'd1800;
  localparam int KB_SHIFT = 10;

  typedef enum logic [1:0] {
    REG_TIMEOUT = 2'd0,
    REG_KBYTE_LIMIT = 2'd1,
    REG_HIT_LIMIT = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_EXISTING = 2'd0,
    ST_CLAIMED = 2'd1,
    ST_NO_FREE = 2'd2
  } status_code_t;

  typedef struct packed {
    logic [63:0] client_addr;
    logic [31:0] now_seconds;
    logic [39:0] file_size;
    logic [30:0] new_id;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [30:0] public_id;
    logic throttled;
    logic [31:0] delay_seconds;
  } rsp_t;

  typedef struct packed {
    logic [31:0] timeout_seconds;
    logic [31:0] kbyte_limit;
    logic [31:0] hit_limit;
  } cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    logic found;
    logic claimed;
    logic [31:0] kbytes;
    logic [31:0] hits;
    logic [30:0] id;
  } job_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_LIVE,
    F_FREE,
    F_UPDATE
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_DONE
  } back_state_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [32:0] b);
    logic [33:0] s;
    s = {2'b00, a} + {1'b0, b};
    return (s[33:32] != 2'b00) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

FILE: hw/rtl/csrl_front.sv
// front end: table scan for a live or free entry and counter update
module csrl_front #(
  parameter int SESSIONS = csrl_pkg::SESSIONS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  csrl_pkg::req_t req,
  input  csrl_pkg::cfg_t cfg,
  output logic job_valid,
  input  logic job_ready,
  output csrl_pkg::job_t job
);
  import csrl_pkg::*;

  localparam int IW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
  localparam logic [IW:0] LAST = (IW+1)'(SESSIONS - 1);

  front_state_t state, state_next;
  req_t r;
  logic [IW:0] idx;
  logic [IW-1:0] sel;
  logic sel_claim;
  logic [63:0] e_key [SESSIONS];
  logic [31:0] e_time [SESSIONS];
  logic [31:0] e_hits [SESSIONS];
  logic [31:0] e_kb [SESSIONS];
  logic [30:0] e_id [SESSIONS];
  logic [31:0] age;
  logic [IW-1:0] ia;
  logic [31:0] nh, nk;

  assign ia = idx[IW-1:0];
  assign age = r.now_seconds - e_time[ia];
  assign nh = sat_add32(sel_claim ? 32'd0 : e_hits[sel], 33'd1);
  assign nk = sat_add32(sel_claim ? 32'd0 : e_kb[sel], {3'd0, r.file_size[39:KB_SHIFT]});

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: if (push) state_next = F_LIVE;
      F_LIVE: begin
        if (e_key[ia] == r.client_addr && age < cfg.timeout_seconds) state_next = F_UPDATE;
        else if (idx == LAST) state_next = F_FREE;
      end
      F_FREE: begin
        if (age > cfg.timeout_seconds) state_next = F_UPDATE;
        else if (idx == LAST && job_ready) state_next = F_IDLE;
      end
      F_UPDATE: if (job_ready) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    full = (state != F_IDLE);
    job_valid = 1'b0;
    job = '0;
    if (state == F_UPDATE) begin
      job_valid = 1'b1;
      job.found = 1'b1;
      job.claimed = sel_claim;
      job.hits = nh;
      job.kbytes = nk;
      job.id = sel_claim ? r.new_id : e_id[sel];
    end else if (state == F_FREE && idx == LAST && !(age > cfg.timeout_seconds)) begin
      job_valid = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      idx <= '0;
    end else begin
      state <= state_next;
      if (state == F_IDLE) begin
        idx <= '0;
      end else if (state == F_LIVE) begin
        if (state_next == F_LIVE) idx <= idx + 1'b1;
        else if (state_next == F_FREE) idx <= '0;
      end else if (state == F_FREE && state_next == F_FREE && idx != LAST) begin
        idx <= idx + 1'b1;
      end
    end
    if (state == F_IDLE && push) r <= req;
    if ((state == F_LIVE || state == F_FREE) && state_next == F_UPDATE) begin
      sel <= ia;
      sel_claim <= (state == F_FREE);
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SESSIONS; k++) begin
      if (rst) begin
        e_key[k] <= '0;
        e_time[k] <= '0;
        e_hits[k] <= '0;
        e_kb[k] <= '0;
        e_id[k] <= '0;
      end else if (state == F_UPDATE && job_ready && sel == IW'(k)) begin
        e_key[k] <= r.client_addr;
        e_time[k] <= r.now_seconds;
        e_hits[k] <= nh;
        e_kb[k] <= nk;
        e_id[k] <= job.id;
      end
    end
  end

  a_full_busy: assert property (@(posedge clk) disable iff (rst)
    (state == F_IDLE && push) |=> full) else $error("front took no item");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    idx <= LAST) else $error("scan index out of range");
  a_job_hold: assert property (@(posedge clk) disable iff (rst)
    (job_valid && !job_ready && state == F_UPDATE) |=> job_valid)
    else $error("job dropped");
endmodule

FILE: hw/rtl/csrl_back.sv
// back end: limit compare, two serial divisions and result register
module csrl_back (
  input  logic clk,
  input  logic rst,
  input  logic job_valid,
  output logic job_ready,
  input  csrl_pkg::job_t job,
  input  csrl_pkg::cfg_t cfg,
  output logic empty,
  input  logic pop,
  output csrl_pkg::rsp_t rsp
);
  import csrl_pkg::*;

  back_state_t state, state_next;
  job_t j;
  logic [5:0] cnt;
  logic [31:0] qk, qh;
  logic [32:0] rk, rh;
  logic [32:0] tk, th;
  logic thr;

  assign tk = {rk[31:0], qk[31]};
  assign th = {rh[31:0], qh[31]};
  assign thr = (cfg.kbyte_limit != 0 && j.kbytes > cfg.kbyte_limit) ||
               (cfg.hit_limit != 0 && j.hits > cfg.hit_limit);

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (job_valid) state_next = job.found ? B_DIV : B_DONE;
      B_DIV: if (cnt == 6'd31) state_next = B_DONE;
      B_DONE: if (pop) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    job_ready = (state == B_IDLE);
    empty = (state != B_DONE);
    rsp = '0;
    if (j.found) begin
      rsp.status = j.claimed ? ST_CLAIMED : ST_EXISTING;
      rsp.public_id = j.id;
      rsp.throttled = thr;
      if (thr) begin
        rsp.delay_seconds = (cfg.kbyte_limit != 0 ? qk : 32'd0) >
                            (cfg.hit_limit != 0 ? qh : 32'd0)
                            ? (cfg.kbyte_limit != 0 ? qk : 32'd0)
                            : (cfg.hit_limit != 0 ? qh : 32'd0);
      end
    end else begin
      rsp.status = ST_NO_FREE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= (state == B_DIV && state_next == B_DIV) ? cnt + 6'd1 : 6'd0;
    end
    if (state == B_IDLE && job_valid) begin
      j <= job;
      qk <= job.kbytes;
      qh <= job.hits;
      rk <= '0;
      rh <= '0;
    end else if (state == B_DIV) begin
      if (tk >= {1'b0, cfg.kbyte_limit}) begin
        rk <= tk - {1'b0, cfg.kbyte_limit};
        qk <= {qk[30:0], 1'b1};
      end else begin
        rk <= tk;
        qk <= {qk[30:0], 1'b0};
      end
      if (th >= {1'b0, cfg.hit_limit}) begin
        rh <= th - {1'b0, cfg.hit_limit};
        qh <= {qh[30:0], 1'b1};
      end else begin
        rh <= th;
        qh <= {qh[30:0], 1'b0};
      end
    end
  end

  a_cnt_idle: assert property (@(posedge clk) disable iff (rst)
    (state != B_DIV) |-> (cnt == 6'd0)) else $error("divider count stale");
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !(job_ready && !empty)) else $error("back busy and idle");
  a_div_len: assert property (@(posedge clk) disable iff (rst)
    (state == B_DIV && cnt == 6'd31) |=> (state == B_DONE)) else $error("divider overran");
endmodule

FILE: hw/rtl/client_session_rate_limiter_top.sv
// top level of the client session rate limiter
// scan: a live entry is found by scanning from index 0; a claim follows a full live scan
// and a free scan up to the claimed index; with no free entry there is no division
// throughput: front and back each take one request at a time and the two overlap,
// set by the sequential table scan and the bit-serial 32-step divider
// reset: synchronous rst clears the session table, sets timeout 1800 and limits 0
module client_session_rate_limiter_top #(
  parameter int SESSIONS = csrl_pkg::SESSIONS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  csrl_pkg::req_t req,
  output logic empty,
  input  logic pop,
  output csrl_pkg::rsp_t rsp,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  import csrl_pkg::*;

  cfg_t cfg;
  logic job_valid, job_ready;
  job_t job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_seconds <= TIMEOUT_RESET;
      cfg.kbyte_limit <= '0;
      cfg.hit_limit <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TIMEOUT: cfg.timeout_seconds <= cfg_data;
        REG_KBYTE_LIMIT: cfg.kbyte_limit <= cfg_data;
        REG_HIT_LIMIT: cfg.hit_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  csrl_front #(.SESSIONS(SESSIONS)) u_front (
    .clk, .rst, .push, .full, .req, .cfg,
    .job_valid, .job_ready, .job
  );

  csrl_back u_back (
    .clk, .rst, .job_valid, .job_ready, .job, .cfg,
    .empty, .pop, .rsp
  );
endmodule

FILE: tb/client_session_rate_limiter_top_tb.sv
// self-checking testbench for the client session rate limiter top level
module client_session_rate_limiter_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import csrl_pkg::*;

  localparam int NSESS = 16;
  localparam int SETTLE = 120;
  localparam logic [1:0] REG_UNKNOWN = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  req_t req = '0;
  logic empty;
  logic pop = 1'b0;
  rsp_t rsp;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_TIMEOUT;
  logic [31:0] cfg_data = '0;

  client_session_rate_limiter_top dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .req(req),
    .empty(empty), .pop(pop), .rsp(rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor copy of the session table and settings
  logic [63:0] tbl_key [NSESS];
  logic [31:0] tbl_time [NSESS];
  logic [31:0] tbl_hits [NSESS];
  logic [31:0] tbl_kbytes [NSESS];
  logic [30:0] tbl_id [NSESS];
  logic [31:0] set_timeout = TIMEOUT_RESET;
  logic [31:0] set_kb_limit = '0;
  logic [31:0] set_hit_limit = '0;

  req_t req_pending [$];
  rsp_t rsp_expected [$];
  int mismatches = 0;
  int beats_in = 0;
  int beats_out = 0;
  int claims = 0;
  int throttles = 0;
  int no_free = 0;
  int gap_left = 0;
  int stall_left = 0;
  logic hold_pop = 1'b0;

  function automatic logic [31:0] sat_sum(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic rsp_t predict_session(input req_t r);
    rsp_t o;
    int hit;
    logic [31:0] age, dk, dh;
    logic thr;
    hit = -1;
    o = '0;
    o.status = ST_EXISTING;
    for (int k = 0; k < NSESS; k++) begin
      age = r.now_seconds - tbl_time[k];
      if (hit < 0 && tbl_key[k] == r.client_addr && age < set_timeout) hit = k;
    end
    if (hit < 0) begin
      for (int k = 0; k < NSESS; k++) begin
        age = r.now_seconds - tbl_time[k];
        if (hit < 0 && age > set_timeout) begin
          hit = k;
          tbl_key[k] = r.client_addr;
          tbl_hits[k] = '0;
          tbl_kbytes[k] = '0;
          tbl_id[k] = r.new_id;
          o.status = ST_CLAIMED;
        end
      end
    end
    if (hit < 0) begin
      o.status = ST_NO_FREE;
      return o;
    end
    tbl_time[hit] = r.now_seconds;
    tbl_hits[hit] = sat_sum(tbl_hits[hit], 32'd1);
    tbl_kbytes[hit] = sat_sum(tbl_kbytes[hit], 32'(r.file_size >> 10));
    thr = (set_kb_limit != 0 && tbl_kbytes[hit] > set_kb_limit) ||
          (set_hit_limit != 0 && tbl_hits[hit] > set_hit_limit);
    dk = (set_kb_limit != 0) ? tbl_kbytes[hit] / set_kb_limit : 32'd0;
    dh = (set_hit_limit != 0) ? tbl_hits[hit] / set_hit_limit : 32'd0;
    o.public_id = tbl_id[hit];
    o.throttled = thr;
    o.delay_seconds = thr ? ((dk > dh) ? dk : dh) : 32'd0;
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        rsp_expected.push_back(predict_session(req));
        beats_in++;
      end
      if (!push || !full) begin
        if (gap_left > 0) begin
          gap_left--;
          push <= 1'b0;
        end else if (req_pending.size() > 0) begin
          req <= req_pending.pop_front();
          push <= 1'b1;
          gap_left = pick_gap();
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        beats_out++;
        if (rsp_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat %p", rsp);
        end else begin
          want = rsp_expected.pop_front();
          if (want.status == ST_CLAIMED) claims++;
          if (want.status == ST_NO_FREE) no_free++;
          if (want.throttled) throttles++;
          if (rsp.status !== want.status || rsp.public_id !== want.public_id ||
              rsp.throttled !== want.throttled ||
              rsp.delay_seconds !== want.delay_seconds) begin
            mismatches++;
            if (mismatches <= 10)
              $display("beat %0d: expected %p actual %p", beats_out, want, rsp);
          end
        end
      end
      if (hold_pop) begin
        pop <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_TIMEOUT: set_timeout = val;
      REG_KBYTE_LIMIT: set_kb_limit = val;
      REG_HIT_LIMIT: set_hit_limit = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    while (req_pending.size() > 0 || push || rsp_expected.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic add_req(input logic [63:0] a, input logic [31:0] t,
                         input logic [39:0] s, input logic [30:0] id);
    req_t r;
    r.client_addr = a;
    r.now_seconds = t;
    r.file_size = s;
    r.new_id = id;
    req_pending.push_back(r);
  endtask

  logic [63:0] key_pool [8];
  logic [31:0] clock_now = '0;

  task automatic random_phase(input int n, input logic [31:0] span);
    logic [63:0] a;
    logic [39:0] s;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 85) clock_now = clock_now + $urandom_range(0, span);
      else if (r < 93) clock_now = $urandom;
      else clock_now = clock_now - $urandom_range(0, 50);
      a = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, 7)]
                                     : {$urandom, $urandom};
      r = $urandom_range(0, 9);
      if (r < 6) s = 40'($urandom_range(0, 20000));
      else if (r < 9) s = {8'($urandom), $urandom};
      else s = 40'hFF_FFFF_FFFF;
      add_req(a, clock_now, s, 31'($urandom));
    end
  endtask

  task automatic run_phase(input logic [31:0] tmo, input logic [31:0] kb,
                           input logic [31:0] hl, input int n, input logic [31:0] span);
    wait_idle();
    write_reg(REG_TIMEOUT, tmo);
    write_reg(REG_KBYTE_LIMIT, kb);
    write_reg(REG_HIT_LIMIT, hl);
    random_phase(n, span);
  endtask

  initial begin
    for (int k = 0; k < NSESS; k++) begin
      tbl_key[k] = '0;
      tbl_time[k] = '0;
      tbl_hits[k] = '0;
      tbl_kbytes[k] = '0;
      tbl_id[k] = '0;
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int k = 2; k < 8; k++) key_pool[k] = {$urandom, $urandom};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    write_reg(REG_UNKNOWN, 32'hDEAD_BEEF);
    write_reg(REG_TIMEOUT, TIMEOUT_RESET);
    write_reg(REG_KBYTE_LIMIT, 32'd0);
    write_reg(REG_HIT_LIMIT, 32'd0);
    add_req('0, 32'd0, 40'd0, 31'd1);
    add_req(64'd5, 32'd10, 40'd1023, 31'd2);
    add_req(64'd5, 32'd5000, 40'd1024, 31'h7FFF_FFFF);
    for (int i = 0; i < 5; i++) add_req(64'd5, 32'd5001, 40'hFF_FFFF_FFFF, 31'd3);
    add_req(64'd5, 32'd6801, 40'd0, 31'd4);
    add_req('1, 32'd3000, 40'd2048, 31'd5);
    add_req('1, 32'd2999, 40'd2048, 31'd6);
    add_req(64'd7, 32'hFFFF_FFFF, 40'd100, 31'd7);
    add_req(64'd7, 32'hFFFF_FFFF, 40'd100, 31'd8);
    wait_idle();
    write_reg(REG_KBYTE_LIMIT, 32'd1);
    write_reg(REG_HIT_LIMIT, 32'd1);
    add_req(64'd9, 32'd12000, 40'd4096, 31'd9);
    add_req(64'd9, 32'd12001, 40'd10240, 31'd10);
    add_req(64'd9, 32'd12002, 40'd0, 31'd11);
    wait_idle();
    write_reg(REG_KBYTE_LIMIT, 32'hFFFF_FFFF);
    write_reg(REG_HIT_LIMIT, 32'hFFFF_FFFF);
    add_req(64'd9, 32'd12003, 40'hFF_FFFF_FFFF, 31'd12);
    clock_now = 32'd20000;
    run_phase(TIMEOUT_RESET, 32'd0, 32'd0, 200, 300);
    fork
      begin
        wait (beats_in > 300);
        @(posedge clk);
        hold_pop <= 1'b1;
        repeat (1500) @(posedge clk);
        hold_pop <= 1'b0;
      end
    join_none
    run_phase(32'd100, 32'd50, 32'd3, 250, 40);
    run_phase(32'd0, 32'd1, 32'd1, 200, 3);
    run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 200, 1000);
    run_phase(32'd1, 32'd0, 32'd2, 200, 3);
    run_phase(32'd500, 32'd1000, 32'd0, 250, 120);
    run_phase(32'd30, 32'd0, 32'd5, 250, 12);
    run_phase(32'd1000, 32'd20, 32'd7, 200, 200);
    wait_idle();
    $display("%0d requests sent, %0d results checked over 10 settings", beats_in, beats_out);
    $display("%0d claims, %0d throttled, %0d with no free entry", claims, throttles, no_free);
    if (mismatches == 0) begin
      $display("client_session_rate_limiter_top: match");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("client_session_rate_limiter_top: mismatch");
    end
    $finish;
  end

  initial begin
    #(12 * 3_000_000);
    $display("timeout");
    $display("client_session_rate_limiter_top: mismatch");
    $finish;
  end

endmodule
